// File: hw/rtl/gsa_pkg.sv
// gsa_pkg: shared types and constants for the generational slot allocator
// no dependencies
package gsa_pkg;
  localparam int MaxSlots = 256;
  localparam int RefBits = 16;
  localparam int IdxW = 9;
  localparam int GenW = 32;

  typedef enum logic [1:0] {
    MODE_ALLOC = 2'd0,
    MODE_CHECK = 2'd1,
    MODE_RETAIN = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOT_ACTIVE = 2'd2,
    ST_NO_FREE = 2'd3
  } status_t;

  // word circulating along the ring of slot cells
  typedef struct packed {
    logic [RefBits-1:0] cnt;
    logic [GenW-1:0] gen;
  } slot_word_t;
endpackage

// File: hw/rtl/gsa_cell.sv
// gsa_cell: one register stage of the slot ring
// depends on gsa_pkg
module gsa_cell (
  input  logic               clk,
  input  logic               rst,
  input  logic               shift,
  input  gsa_pkg::slot_word_t d,
  output gsa_pkg::slot_word_t q
);
  import gsa_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= '0;
    end else if (shift) begin
      q <= d;
    end
  end
endmodule

// File: hw/rtl/generational_slot_allocator_top.sv
// generational_slot_allocator_top: slot allocator on a rotating ring of cells
// depends on gsa_pkg and gsa_cell
//
// The slot table sits in a ring of 256 cells that rotates one slot per clock
// while a command scans. Cell 0 always holds the slot under the head pointer.
// A command scans while the ring turns once fully, then passes a state that
// settles the result, and then comes the done cycle. A new start can be taken
// in the done cycle. Each slot is examined and updated as it passes the head
// cell. Results come with done for one cycle and cannot be stalled. Reset
// clears every cell at once.
module generational_slot_allocator_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [8:0]  handle_index,
  input  logic [31:0] handle_generation,
  output logic        done,
  output logic [1:0]  status,
  output logic [8:0]  new_index,
  output logic [31:0] new_generation,
  output logic [8:0]  slots_in_use,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data
);
  import gsa_pkg::*;

  localparam int PosW = $clog2(MaxSlots);
  localparam logic [RefBits-1:0] RefMax = '1;
  localparam logic [GenW-1:0] GenMax = '1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state;
  logic [8:0] slot_count;
  logic [8:0] used_slots;
  logic [8:0] active;
  // latched command
  mode_t cmd_mode;
  logic [8:0] cmd_idx;
  logic [31:0] cmd_gen;
  // scan position = slot index now at the head cell
  logic [PosW-1:0] pos;
  logic found;     // allocate already placed
  logic hit;       // handle matched (check/retain/release)
  logic sat;       // retain hit a saturated count
  logic [8:0] res_idx;
  logic [31:0] res_gen;

  slot_word_t ring [MaxSlots];
  slot_word_t head_new;
  logic in_range;
  logic is_target;
  logic can_alloc;

  assign cfg_ready = (state == S_IDLE) && !start;
  assign busy = (state != S_IDLE);
  assign active = (slot_count > 9'(MaxSlots)) ? 9'(MaxSlots) : slot_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_count <= '0;
    end else if (cfg_valid && cfg_ready) begin
      slot_count <= cfg_data;
    end
  end

  // per-slot decision at the head cell
  always_comb begin
    in_range = {1'b0, pos} < active;
    is_target = (cmd_idx != '0) && ({1'b0, pos} == cmd_idx - 9'd1) && in_range
                && (ring[0].cnt != '0) && (ring[0].gen == cmd_gen);
    can_alloc = in_range && !found && (ring[0].cnt == '0) && (ring[0].gen != GenMax);
    head_new = ring[0];
    if (state == S_SCAN) begin
      unique case (cmd_mode)
        MODE_ALLOC: begin
          if (can_alloc && cmd_idx == '0 && cmd_gen == '0) begin
            head_new.gen = ring[0].gen + 32'd1;
            head_new.cnt = RefBits'(1);
          end
        end
        MODE_RETAIN: begin
          if (is_target && ring[0].cnt != RefMax) head_new.cnt = ring[0].cnt + RefBits'(1);
        end
        MODE_RELEASE: begin
          if (is_target) head_new.cnt = ring[0].cnt - RefBits'(1);
        end
        default: ;
      endcase
    end
  end

  // the ring: head feeds last cell, each cell hands to its lower neighbor
  genvar g;
  generate
    for (g = 0; g < MaxSlots; g++) begin : g_ring
      if (g == MaxSlots - 1) begin : g_last
        gsa_cell u_cell (.clk(clk), .rst(rst), .shift(state == S_SCAN),
                         .d(head_new), .q(ring[g]));
      end else begin : g_mid
        gsa_cell u_cell (.clk(clk), .rst(rst), .shift(state == S_SCAN),
                         .d(ring[g+1]), .q(ring[g]));
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used_slots <= '0;
      cmd_mode <= MODE_CHECK;
      cmd_idx <= '0;
      cmd_gen <= '0;
      pos <= '0;
      found <= 1'b0;
      hit <= 1'b0;
      sat <= 1'b0;
      res_idx <= '0;
      res_gen <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_mode <= mode_t'(mode);
            cmd_idx <= handle_index;
            cmd_gen <= handle_generation;
            pos <= '0;
            found <= 1'b0;
            hit <= 1'b0;
            sat <= 1'b0;
            res_idx <= '0;
            res_gen <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          pos <= pos + PosW'(1);
          if (cmd_mode == MODE_ALLOC && can_alloc && cmd_idx == '0 && cmd_gen == '0) begin
            found <= 1'b1;
            res_idx <= {1'b0, pos} + 9'd1;
            res_gen <= ring[0].gen + 32'd1;
            used_slots <= used_slots + 9'd1;
          end
          if (is_target) begin
            hit <= 1'b1;
            sat <= (ring[0].cnt == RefMax);
            if (cmd_mode == MODE_RELEASE && ring[0].cnt == RefBits'(1))
              used_slots <= used_slots - 9'd1;
          end
          if (pos == PosW'(MaxSlots - 1)) state <= S_DONE;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word, valid while done is high
  always_comb begin
    status = ST_OK;
    new_index = '0;
    new_generation = '0;
    unique case (cmd_mode)
      MODE_ALLOC: begin
        if (cmd_idx != '0 || cmd_gen != '0) status = ST_INVALID;
        else if (active == '0) status = ST_NOT_ACTIVE;
        else if (!found) status = ST_NO_FREE;
        else begin
          new_index = res_idx;
          new_generation = res_gen;
        end
      end
      MODE_CHECK: if (!hit) status = ST_INVALID;
      MODE_RETAIN: if (!hit || sat) status = ST_INVALID;
      MODE_RELEASE: if (!(cmd_idx == '0 && cmd_gen == '0) && !hit) status = ST_INVALID;
      default: ;
    endcase
  end
  assign slots_in_use = used_slots;

`ifndef NO_ASSERTIONS
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> state == S_IDLE)
    else $error("done outside idle");
  a_start_scan: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> state == S_SCAN) else $error("start not taken");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready) |-> !busy) else $error("config during command");
`endif
endmodule

// File: tb/gsa_checker.sv
// gsa_checker: watches the command, result and config channels of the slot allocator
// predicts every result word and compares it; depends on gsa_pkg
module gsa_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  mode,
  input  logic [8:0]  handle_index,
  input  logic [31:0] handle_generation,
  input  logic        done,
  input  logic [1:0]  status,
  input  logic [8:0]  new_index,
  input  logic [31:0] new_generation,
  input  logic [8:0]  slots_in_use,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [8:0]  cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gsa_pkg::*;

  typedef struct packed {
    status_t     st;
    logic [8:0]  idx;
    logic [31:0] gen;
    logic [8:0]  used;
  } alloc_reply_t;

  logic [RefBits-1:0] refs [MaxSlots];
  logic [GenW-1:0]    gens [MaxSlots];
  logic [8:0]         used;
  logic [8:0]         slot_limit;
  alloc_reply_t       replies_due[$];

  assign pending = replies_due.size();

  function automatic int active_slots();
    return (slot_limit > MaxSlots) ? MaxSlots : int'(slot_limit);
  endfunction

  function automatic bit handle_live(logic [8:0] hi, logic [31:0] hg);
    if (hi == 0 || hi > active_slots()) return 0;
    return (refs[hi-1] != 0) && (gens[hi-1] == hg);
  endfunction

  // apply one command to the shadow table and queue its reply
  task automatic predict_slot_op(mode_t m, logic [8:0] hi, logic [31:0] hg);
    alloc_reply_t r;
    int i;
    int n;
    r = '{st: ST_OK, idx: '0, gen: '0, used: '0};
    n = active_slots();
    case (m)
      MODE_ALLOC: begin
        if (hi != 0 || hg != 0) r.st = ST_INVALID;
        else if (n == 0) r.st = ST_NOT_ACTIVE;
        else begin
          for (i = 0; i < n; i++)
            if (refs[i] == 0 && gens[i] != '1) break;
          if (i == n) r.st = ST_NO_FREE;
          else begin
            gens[i] = gens[i] + 32'd1;
            refs[i] = RefBits'(1);
            used = used + 9'd1;
            r.idx = 9'(i + 1);
            r.gen = gens[i];
          end
        end
      end
      MODE_CHECK: if (!handle_live(hi, hg)) r.st = ST_INVALID;
      MODE_RETAIN: begin
        if (!handle_live(hi, hg) || refs[hi-1] == '1) r.st = ST_INVALID;
        else refs[hi-1] = refs[hi-1] + RefBits'(1);
      end
      default: begin
        if (hi != 0 || hg != 0) begin
          if (!handle_live(hi, hg)) r.st = ST_INVALID;
          else begin
            refs[hi-1] = refs[hi-1] - RefBits'(1);
            if (refs[hi-1] == 0) used = used - 9'd1;
          end
        end
      end
    endcase
    r.used = used;
    replies_due.push_back(r);
  endtask

  always @(posedge clk) begin
    alloc_reply_t e;
    if (rst) begin
      for (int k = 0; k < MaxSlots; k++) begin
        refs[k] = '0;
        gens[k] = '0;
      end
      used = '0;
      slot_limit = '0;
      errors <= 0;
      replies_due.delete();
    end else begin
      if (done) begin
        if (replies_due.size() == 0) begin
          if (errors < 10) $display("%0t: unexpected result word", $realtime);
          errors <= errors + 1;
        end else begin
          e = replies_due.pop_front();
          if (status !== e.st || new_index !== e.idx || new_generation !== e.gen ||
              slots_in_use !== e.used) begin
            if (errors < 10)
              $display({"%0t: mismatch exp st=%0d idx=%0d gen=%h used=%0d",
                        " got st=%0d idx=%0d gen=%h used=%0d"},
                       $realtime, e.st, e.idx, e.gen, e.used,
                       status, new_index, new_generation, slots_in_use);
            errors <= errors + 1;
          end
        end
      end
      if (cfg_valid && cfg_ready) slot_limit = cfg_data;
      if (start && !busy) predict_slot_op(mode_t'(mode), handle_index, handle_generation);
    end
  end
endmodule

// File: tb/generational_slot_allocator_top_tb.sv
// generational_slot_allocator_top_tb: stimulus and verdict for the slot allocator
// depends on gsa_pkg, gsa_checker and generational_slot_allocator_top
module generational_slot_allocator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gsa_pkg::*;

  localparam int StallLimit = 4000; // cycles without any handshake

  typedef struct {
    logic [8:0]  idx;
    logic [31:0] gen;
  } handle_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        start = 0;
  logic        busy;
  logic [1:0]  mode = MODE_CHECK;
  logic [8:0]  handle_index = '0;
  logic [31:0] handle_generation = '0;
  logic        done;
  logic [1:0]  status;
  logic [8:0]  new_index;
  logic [31:0] new_generation;
  logic [8:0]  slots_in_use;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  int          errors;
  int          pending;
  int          idle_pct;
  int          quiet;
  handle_t     held[$];   // handles the stimulus believes hold a reference

  generational_slot_allocator_top u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .handle_index(handle_index), .handle_generation(handle_generation),
    .done(done), .status(status), .new_index(new_index),
    .new_generation(new_generation), .slots_in_use(slots_in_use),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  gsa_checker u_chk (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .mode(mode),
    .handle_index(handle_index), .handle_generation(handle_generation),
    .done(done), .status(status), .new_index(new_index),
    .new_generation(new_generation), .slots_in_use(slots_in_use),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // watchdog: any handshake or result word resets the count
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // register write, only issued while nothing is outstanding
  task automatic write_slot_count(logic [8:0] v);
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);  // let the ring finish its last pass
    cfg_valid <= 1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  // one command word; waits for its result and tracks live handles
  // pos is the list entry used by a release, -1 if none
  task automatic issue(mode_t m, logic [8:0] hi, logic [31:0] hg, int pos);
    while ($urandom_range(99) < idle_pct) @(posedge clk);
    start <= 1;
    mode <= m;
    handle_index <= hi;
    handle_generation <= hg;
    @(posedge clk);
    while (busy) @(posedge clk);
    start <= 0;
    @(posedge clk);
    while (!done) @(posedge clk);
    if (status == ST_OK) begin
      case (m)
        MODE_ALLOC:   held.push_back('{new_index, new_generation});
        MODE_RETAIN:  held.push_back('{hi, hg});
        MODE_RELEASE: if (pos >= 0 && pos < held.size()) held.delete(pos);
        default: ;
      endcase
    end
  endtask

  // random word: mostly real handles, some corrupted or random noise
  task automatic random_word();
    int      r;
    int      pos;
    handle_t h;
    mode_t   m;
    r = $urandom_range(99);
    pos = -1;
    if (r < 30 || held.size() == 0) begin
      if ($urandom_range(9) == 0) issue(MODE_ALLOC, 9'($urandom), $urandom, -1);
      else issue(MODE_ALLOC, '0, '0, -1);
    end else begin
      m = mode_t'($urandom_range(1, 3));
      pos = $urandom_range(held.size() - 1);
      h = held[pos];
      r = $urandom_range(99);
      if (r < 10) h.gen = h.gen ^ (32'd1 << $urandom_range(31));
      else if (r < 15) h.idx = 9'($urandom);
      else if (r < 20) h.gen = $urandom;
      else if (r < 23) h = '{'0, '0};
      issue(m, h.idx, h.gen, (m == MODE_RELEASE && r >= 23) ? pos : -1);
    end
  endtask

  initial begin
    idle_pct = 8;
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: store not active
    issue(MODE_ALLOC, '0, '0, -1);
    issue(MODE_CHECK, 9'd1, '0, -1);
    issue(MODE_RELEASE, '0, '0, -1);
    // one slot: fill it, then no free slot
    write_slot_count(9'd1);
    issue(MODE_ALLOC, '0, '0, -1);
    issue(MODE_ALLOC, '0, '0, -1);
    issue(MODE_ALLOC, 9'd0, 32'hffff_ffff, -1);
    issue(MODE_ALLOC, 9'h1ff, 32'd0, -1);
    issue(MODE_CHECK, 9'd1, 32'd1, -1);
    issue(MODE_CHECK, 9'd2, 32'd1, -1);
    issue(MODE_CHECK, 9'h1ff, 32'hffff_ffff, -1);
    issue(MODE_RETAIN, 9'd1, 32'd1, -1);
    issue(MODE_RELEASE, 9'd1, 32'd2, -1);
    issue(MODE_RELEASE, 9'd1, 32'd1, 0);
    issue(MODE_RELEASE, 9'd1, 32'd1, 0);
    issue(MODE_RELEASE, 9'd1, 32'd1, -1);   // count already zero
    issue(MODE_ALLOC, '0, '0, -1);           // generation bumps to two
    // shrinking hides the live slot, growing brings it back
    write_slot_count(9'd0);
    issue(MODE_CHECK, 9'd1, 32'd2, -1);
    write_slot_count(9'h1ff);              // above the table size
    issue(MODE_CHECK, 9'd1, 32'd2, -1);
    issue(MODE_ALLOC, '0, '0, -1);
    issue(MODE_CHECK, 9'd256, 32'd0, -1);
    issue(MODE_CHECK, 9'd257, 32'd0, -1);

    // random phases over several table sizes, idling changes by thirds
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_slot_count(9'd4);
        1: write_slot_count(9'd256);
        2: write_slot_count(9'd2);
        3: write_slot_count(9'd7);
        4: write_slot_count(9'd1);
        default: write_slot_count(9'd3);
      endcase
      idle_pct = (ph < 2) ? 8 : (ph < 4) ? 74 : 0;
      for (int k = 0; k < 92; k++) random_word();
    end

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_cell.sv
hw/rtl/generational_slot_allocator_top.sv
tb/gsa_checker.sv
tb/generational_slot_allocator_top_tb.sv
